FILE: rtl/mexp_pkg.sv
package mexp_pkg;

    // Port width of every operand and of the result
    localparam int DATA_W = 32;

    typedef logic [DATA_W-1:0] t_word;

endpackage

FILE: rtl/mexp_if.sv
interface mexp_in_if;
    import mexp_pkg::*;

    logic  valid;
    logic  ready;
    t_word base_value;
    t_word exponent;
    t_word modulus;

    modport source (output valid, output base_value, output exponent, output modulus,
                    input ready);
    modport sink   (input valid, input base_value, input exponent, input modulus,
                    output ready);
endinterface

interface mexp_out_if;
    import mexp_pkg::*;

    logic  valid;
    logic  ready;
    t_word power_residue;

    modport source (output valid, output power_residue, input ready);
    modport sink   (input valid, input power_residue, output ready);
endinterface

FILE: rtl/mexp_mul.sv
module mexp_mul #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [OPERAND_WIDTH-1:0] i_a,
    input  logic [OPERAND_WIDTH-1:0] i_b,
    input  logic [OPERAND_WIDTH-1:0] i_m,
    output logic                     o_done,
    output logic [OPERAND_WIDTH-1:0] o_prod
);
    // Interleaved shift-add modular multiply, one bit of i_a per cycle.
    // Needs i_b < i_m (i_m nonzero); i_b and i_m held stable while busy.
    localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);
    localparam int SUM_W = OPERAND_WIDTH + 2;

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [OPERAND_WIDTH-1:0] r_a;
    logic [OPERAND_WIDTH-1:0] r_r;

    logic [SUM_W-1:0]         sum;
    logic [SUM_W-1:0]         mod_ext;
    logic [SUM_W-1:0]         red1;
    logic [SUM_W-1:0]         red2;

    // 2r + a_bit*b < 3m, so two conditional subtracts bring it below m
    always_comb begin
        mod_ext = SUM_W'(i_m);
        sum     = {1'b0, r_r, 1'b0} + (r_a[OPERAND_WIDTH-1] ? SUM_W'(i_b) : '0);
        red1    = (sum  >= mod_ext) ? sum  - mod_ext : sum;
        red2    = (red1 >= mod_ext) ? red1 - mod_ext : red1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(OPERAND_WIDTH);
                r_a    <= i_a;
                r_r    <= '0;
            end else if (r_busy) begin
                r_r   <= red2[OPERAND_WIDTH-1:0];
                r_a   <= {r_a[OPERAND_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_r;

endmodule

FILE: rtl/modular_exponentiation_unit.sv
// The base is first reduced mod m; then for each exponent bit, MSB first, the residue is
// squared, and multiplied by the base when the bit is set (W = OPERAND_WIDTH bits in all);
// the result is then loaded into the output register, once that register is free.
// Exponent zero or modulus zero: the result is loaded without using the multiplier.
// One item at a time; the shared bit-serial multiplier does every step.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_out.valid.
module modular_exponentiation_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mexp_in_if.sink    i_in,
    mexp_out_if.source o_out
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);

    typedef logic [OPERAND_WIDTH-1:0] t_opnd;

    // S_RED   : base mod m, run as base * 1 through the multiplier
    // S_SQR   : acc = acc^2 mod m
    // S_MUL   : acc = acc * b mod m, only for set exponent bits
    // S_DONE  : waits for the output register to free up
    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_SQR,
        S_MUL,
        S_DONE
    } t_state;

    t_state           r_state;
    logic             r_start;      // start pulse to the multiplier
    t_opnd            r_acc;        // running residue (holds the base during S_RED)
    t_opnd            r_b;          // reduced base
    t_opnd            r_mod;
    t_opnd            r_exp;        // exponent, scanned MSB first by shifting left
    logic [CNT_W-1:0] r_left;       // exponent bits still to process
    logic             r_out_valid;
    t_word            r_out_data;

    logic             accept;
    logic             mul_done;
    t_opnd            mul_b;
    t_opnd            mul_prod;
    t_opnd            in_exp;
    t_opnd            in_mod;

    assign in_exp = i_in.exponent[OPERAND_WIDTH-1:0];
    assign in_mod = i_in.modulus[OPERAND_WIDTH-1:0];
    assign accept = i_in.valid && i_in.ready;

    // Multiplicand: 1 for the base reduction, the base for multiply steps,
    // the residue itself when squaring. r_acc is the multiplier in every step.
    always_comb begin
        case (r_state)
            S_RED:   mul_b = t_opnd'(1);
            S_MUL:   mul_b = r_b;
            default: mul_b = r_acc;
        endcase
    end

    mexp_mul #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (r_acc),
        .i_b     (mul_b),
        .i_m     (r_mod),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_exp <= in_exp;
                        r_mod <= in_mod;
                        if (in_exp == '0) begin
                            // x^0 is 1 for every modulus, not reduced
                            r_acc   <= t_opnd'(1);
                            r_state <= S_DONE;
                        end else if (in_mod == '0) begin
                            r_acc   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_acc   <= i_in.base_value[OPERAND_WIDTH-1:0];
                            r_start <= 1'b1;
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (mul_done) begin
                        r_b     <= mul_prod;
                        // 1 mod m: zero only for modulus one
                        r_acc   <= (r_mod == t_opnd'(1)) ? '0 : t_opnd'(1);
                        r_left  <= CNT_W'(OPERAND_WIDTH);
                        r_start <= 1'b1;
                        r_state <= S_SQR;
                    end
                end
                S_SQR, S_MUL: begin
                    if (mul_done) begin
                        r_acc <= mul_prod;
                        if (r_state == S_SQR && r_exp[OPERAND_WIDTH-1]) begin
                            r_start <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            // bit finished, move to the next one
                            r_exp  <= {r_exp[OPERAND_WIDTH-2:0], 1'b0};
                            r_left <= r_left - 1'b1;
                            if (r_left == CNT_W'(1)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_start <= 1'b1;
                                r_state <= S_SQR;
                            end
                        end
                    end
                end
                S_DONE: begin
                    // load only once the previous result has been taken
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= t_word'(r_acc);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.power_residue = r_out_data;

endmodule

FILE: rtl/mexp_chk.sv
module mexp_chk #(
    parameter int OPERAND_WIDTH = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic [OPERAND_WIDTH-1:0] i_in_exponent,
    input logic [OPERAND_WIDTH-1:0] i_in_modulus,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input mexp_pkg::t_word       i_out_data
);

    // After reset the unit is idle with nothing on the output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("unit not idle after reset");

    // A real computation (nonzero exponent and modulus) keeps the input closed after the accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_exponent != '0 && i_in_modulus != '0)
        |=> !i_in_ready ##1 !i_in_ready)
        else $error("input reopened during a computation");

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before it was taken");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_data))
        else $error("result changed while stalled");

endmodule

bind modular_exponentiation_unit mexp_chk #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
) u_mexp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_exponent (i_in.exponent[OPERAND_WIDTH-1:0]),
    .i_in_modulus  (i_in.modulus[OPERAND_WIDTH-1:0]),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_data    (o_out.power_residue)
);
